// ===== hw/rtl/clp_pkg.sv =====
// clp_pkg: shared constants, types and register map of the command line parser
// no dependencies; used by the interfaces and all parser modules
package clp_pkg;

  localparam int unsigned LINE_CAPACITY = 32;
  localparam int unsigned LEN_W         = $clog2(LINE_CAPACITY);
  localparam int unsigned SPEED_W       = 21;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned APB_DW        = 32;

  localparam logic [SPEED_W-1:0] ACC_SAT       = 21'd2097151;
  localparam logic [SPEED_W-1:0] SPEED_RESET   = 21'd600000;
  localparam logic [SPEED_W-1:0] MIN_RESET     = 21'd0;
  localparam logic [SPEED_W-1:0] MAX_RESET     = 21'd1200000;

  // register word index (paddr[2])
  localparam logic REG_MIN_SPEED = 1'b0;
  localparam logic REG_MAX_SPEED = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNREC    = 3'd0,
    KIND_RUN      = 3'd1,
    KIND_STOP     = 3'd2,
    KIND_SPEED    = 3'd3,
    KIND_NO_SPEED = 3'd4
  } line_kind_e;

  typedef struct packed {
    line_kind_e         line_kind;
    logic               run_enable;
    logic               stop_request;
    logic [SPEED_W-1:0] ref_speed_milli;
  } res_t;

  typedef struct packed {
    logic [SPEED_W-1:0] min_speed_milli;
    logic [SPEED_W-1:0] max_speed_milli;
  } cfg_t;

endpackage

// ===== hw/rtl/clp_intf.sv =====
// clp_rx_if / clp_res_if: valid/ready channels for received bytes and line results
// depends on clp_pkg for field widths
interface clp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface clp_res_if;
  logic                             valid;
  logic                             ready;
  logic [clp_pkg::KIND_W-1:0]       line_kind;
  logic                             run_enable;
  logic                             stop_request;
  logic [clp_pkg::SPEED_W-1:0]      ref_speed_milli;

  modport source (output valid, output line_kind, output run_enable, output stop_request,
                  output ref_speed_milli, input ready);
  modport sink   (input valid, input line_kind, input run_enable, input stop_request,
                  input ref_speed_milli, output ready);
endinterface

// ===== hw/rtl/clp_cfg_regs.sv =====
// clp_cfg_regs: APB-style register file holding the speed clamp limits
// depends on clp_pkg
module clp_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [clp_pkg::APB_AW-1:0]   paddr,
  input  logic [clp_pkg::APB_DW-1:0]   pwdata,
  output logic [clp_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output clp_pkg::cfg_t                cfg_o
);

  clp_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      if (paddr[2] == clp_pkg::REG_MIN_SPEED) begin
        cfg_d.min_speed_milli = pwdata[clp_pkg::SPEED_W-1:0];
      end else begin
        cfg_d.max_speed_milli = pwdata[clp_pkg::SPEED_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == clp_pkg::REG_MIN_SPEED) begin
      prdata = {{(clp_pkg::APB_DW-clp_pkg::SPEED_W){1'b0}}, cfg_q.min_speed_milli};
    end else begin
      prdata = {{(clp_pkg::APB_DW-clp_pkg::SPEED_W){1'b0}}, cfg_q.max_speed_milli};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_speed_milli <= clp_pkg::MIN_RESET;
      cfg_q.max_speed_milli <= clp_pkg::MAX_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/clp_parser.sv =====
// clp_parser: input byte register, on-the-fly keyword matcher, number accumulator
// and run/speed state; depends on clp_pkg and clp_intf
module clp_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  clp_rx_if.sink          rx,
  input  clp_pkg::cfg_t   cfg_i,
  input  logic            out_free_i,
  output logic            res_load_o,
  output clp_pkg::res_t   res_o
);

  typedef enum logic [4:0] {
    PR_START, PR_R, PR_S, PR_RU, PR_RE, PR_RUN, PR_RUNEQ, PR_RUN1, PR_RUN0, PR_REF,
    PR_ST, PR_SP, PR_STA, PR_STO, PR_STAR, PR_START_FULL, PR_STOP_FULL, PR_SPD,
    PR_NSPACE, PR_NSIGN, PR_NBODY, PR_NEND, PR_DEAD
  } prog_e;

  localparam int unsigned W = clp_pkg::SPEED_W;
  localparam logic [clp_pkg::LEN_W-1:0] LEN_LAST =
    clp_pkg::LEN_W'(clp_pkg::LINE_CAPACITY - 1);

  logic                      in_vld_q, in_vld_d;
  logic [7:0]                in_byte_q;
  logic [clp_pkg::LEN_W-1:0] len_q, len_d;
  prog_e                     prog_q, prog_d;
  logic [W-1:0]              acc_q, acc_d;
  logic [1:0]                frac_q, frac_d;
  logic                      dig_q, dig_d;
  logic                      neg_q, neg_d;
  logic                      fpart_q, fpart_d;
  logic                      run_q, run_d;
  logic [W-1:0]              spd_q, spd_d;

  logic [7:0]   u;
  logic         is_eol, printable, is_dig, close_res, advance, take_dig;
  logic [3:0]   dval;
  logic [W+3:0] int_v;
  logic [W:0]   frac_v;
  logic [9:0]   frac_w;
  logic [W-1:0] num_v;

  assign is_eol    = (in_byte_q == 8'h0A) || (in_byte_q == 8'h0D);
  assign printable = (in_byte_q >= 8'h20) && (in_byte_q <= 8'h7E);
  assign close_res = is_eol && (len_q != '0);
  assign advance   = in_vld_q && (!close_res || out_free_i);
  assign rx.ready  = !in_vld_q || advance;
  assign res_load_o = advance && close_res;

  // fold lower case onto upper case
  assign u      = ((in_byte_q >= 8'h61) && (in_byte_q <= 8'h7A)) ? in_byte_q - 8'd32
                                                               : in_byte_q;
  assign is_dig = (u >= 8'h30) && (u <= 8'h39);
  assign dval   = 4'(u - 8'h30);

  always_comb begin
    case (frac_q)
      2'd0:    frac_w = 10'd100;
      2'd1:    frac_w = 10'd10;
      default: frac_w = 10'd1;
    endcase
  end

  // integer digit: acc*10 + d*1000, fraction digit: acc + d*weight
  assign int_v  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} +
                  (W+4)'({10'd0, dval} * 14'd1000);
  assign frac_v = {1'b0, acc_q} + (W+1)'({6'd0, dval} * frac_w);

  // negative values always fall below a non-negative lower limit; -0 equals 0
  assign num_v = neg_q ? '0 : acc_q;

  always_comb begin
    len_d    = len_q;
    prog_d   = prog_q;
    acc_d    = acc_q;
    frac_d   = frac_q;
    dig_d    = dig_q;
    neg_d    = neg_q;
    fpart_d  = fpart_q;
    run_d    = run_q;
    spd_d    = spd_q;
    take_dig = 1'b0;
    res_o.line_kind = clp_pkg::KIND_UNREC;
    res_o.stop_request = 1'b0;

    if (advance) begin
      if (is_eol) begin
        if (close_res) begin
          if (prog_q == PR_RUN1 || prog_q == PR_START_FULL) begin
            res_o.line_kind = clp_pkg::KIND_RUN;
            run_d = 1'b1;
          end else if (prog_q == PR_RUN0 || prog_q == PR_STOP_FULL) begin
            res_o.line_kind = clp_pkg::KIND_STOP;
            res_o.stop_request = 1'b1;
            run_d = 1'b0;
          end else if (prog_q == PR_NSPACE || prog_q == PR_NSIGN ||
                       prog_q == PR_NBODY || prog_q == PR_NEND) begin
            if (dig_q) begin
              res_o.line_kind = clp_pkg::KIND_SPEED;
              if (num_v < cfg_i.min_speed_milli || neg_q) begin
                spd_d = cfg_i.min_speed_milli;
              end else if (num_v > cfg_i.max_speed_milli) begin
                spd_d = cfg_i.max_speed_milli;
              end else begin
                spd_d = num_v;
              end
            end else begin
              res_o.line_kind = clp_pkg::KIND_NO_SPEED;
            end
          end
        end
        len_d = '0; prog_d = PR_START; acc_d = '0; frac_d = '0;
        dig_d = 1'b0; neg_d = 1'b0; fpart_d = 1'b0;
      end else if (printable) begin
        if (len_q < LEN_LAST) begin
          len_d = len_q + clp_pkg::LEN_W'(1);
          case (prog_q)
            PR_START: prog_d = (u == "R") ? PR_R : ((u == "S") ? PR_S : PR_DEAD);
            PR_R:     prog_d = (u == "U") ? PR_RU : ((u == "E") ? PR_RE : PR_DEAD);
            PR_RU:    prog_d = (u == "N") ? PR_RUN : PR_DEAD;
            PR_RUN:   prog_d = (u == "=") ? PR_RUNEQ : PR_DEAD;
            PR_RUNEQ: prog_d = (u == "1") ? PR_RUN1 : ((u == "0") ? PR_RUN0 : PR_DEAD);
            PR_RE:    prog_d = (u == "F") ? PR_REF : PR_DEAD;
            PR_REF:   prog_d = (u == "=") ? PR_NSPACE : PR_DEAD;
            PR_S:     prog_d = (u == "T") ? PR_ST : ((u == "P") ? PR_SP : PR_DEAD);
            PR_ST:    prog_d = (u == "A") ? PR_STA : ((u == "O") ? PR_STO : PR_DEAD);
            PR_STA:   prog_d = (u == "R") ? PR_STAR : PR_DEAD;
            PR_STAR:  prog_d = (u == "T") ? PR_START_FULL : PR_DEAD;
            PR_STO:   prog_d = (u == "P") ? PR_STOP_FULL : PR_DEAD;
            PR_SP:    prog_d = (u == "D") ? PR_SPD : PR_DEAD;
            PR_SPD:   prog_d = (u == "=") ? PR_NSPACE : PR_DEAD;
            PR_NSPACE: begin
              if (u == " ") begin
                prog_d = PR_NSPACE;
              end else if (u == "+") begin
                prog_d = PR_NSIGN;
              end else if (u == "-") begin
                neg_d  = 1'b1;
                prog_d = PR_NSIGN;
              end else if (is_dig) begin
                take_dig = 1'b1;
                prog_d   = PR_NBODY;
              end else if (u == ".") begin
                fpart_d = 1'b1;
                prog_d  = PR_NBODY;
              end else begin
                prog_d = PR_NEND;
              end
            end
            PR_NSIGN: begin
              if (is_dig) begin
                take_dig = 1'b1;
                prog_d   = PR_NBODY;
              end else if (u == ".") begin
                fpart_d = 1'b1;
                prog_d  = PR_NBODY;
              end else begin
                prog_d = PR_NEND;
              end
            end
            PR_NBODY: begin
              if (is_dig) begin
                take_dig = 1'b1;
              end else if (u == "." && !fpart_q) begin
                fpart_d = 1'b1;
              end else begin
                prog_d = PR_NEND;
              end
            end
            PR_NEND:  prog_d = PR_NEND;
            default:  prog_d = PR_DEAD;
          endcase
          if (take_dig) begin
            dig_d = 1'b1;
            if (!fpart_q) begin
              acc_d = (int_v > (W+4)'(clp_pkg::ACC_SAT)) ? clp_pkg::ACC_SAT : int_v[W-1:0];
            end else if (frac_q != 2'd3) begin
              acc_d  = (frac_v > (W+1)'(clp_pkg::ACC_SAT)) ? clp_pkg::ACC_SAT
                                                           : frac_v[W-1:0];
              frac_d = frac_q + 2'd1;
            end
          end
        end else begin
          // overlong line is dropped, including this byte
          len_d = '0; prog_d = PR_START; acc_d = '0; frac_d = '0;
          dig_d = 1'b0; neg_d = 1'b0; fpart_d = 1'b0;
        end
      end
    end
    res_o.run_enable      = run_d;
    res_o.ref_speed_milli = spd_d;
  end

  always_comb begin
    in_vld_d = in_vld_q;
    if (rx.ready) begin
      in_vld_d = rx.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx.valid && rx.ready) begin
      in_byte_q <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      len_q    <= '0;
      prog_q   <= PR_START;
      acc_q    <= '0;
      frac_q   <= '0;
      dig_q    <= 1'b0;
      neg_q    <= 1'b0;
      fpart_q  <= 1'b0;
      run_q    <= 1'b0;
      spd_q    <= clp_pkg::SPEED_RESET;
    end else begin
      in_vld_q <= in_vld_d;
      len_q    <= len_d;
      prog_q   <= prog_d;
      acc_q    <= acc_d;
      frac_q   <= frac_d;
      dig_q    <= dig_d;
      neg_q    <= neg_d;
      fpart_q  <= fpart_d;
      run_q    <= run_d;
      spd_q    <= spd_d;
    end
  end

endmodule

// ===== hw/rtl/clp_out_reg.sv =====
// clp_out_reg: result register that holds one line result until the receiver takes it
// depends on clp_pkg and clp_intf
module clp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  clp_pkg::res_t  res_i,
  output logic           free_o,
  clp_res_if.source      res
);

  logic          vld_q, vld_d;
  clp_pkg::res_t res_q;

  assign free_o = !vld_q || res.ready;

  always_comb begin
    vld_d = vld_q;
    if (free_o) begin
      vld_d = load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign res.valid           = vld_q;
  assign res.line_kind       = res_q.line_kind;
  assign res.run_enable      = res_q.run_enable;
  assign res.stop_request    = res_q.stop_request;
  assign res.ref_speed_milli = res_q.ref_speed_milli;

endmodule

// ===== hw/rtl/ascii_command_line_parser.sv =====
// ascii_command_line_parser: top level of the serial command line parser
// depends on clp_pkg, clp_intf, clp_cfg_regs, clp_parser, clp_out_reg
//
// usage:
//   rx_i carries one received byte per word. Printable bytes build a line; CR or LF
//   closes a non-empty line and produces one word on res_o (line kind, run enable,
//   stop request, clamped speed reference in milli-rpm). Other bytes give no word.
//   The APB port holds the lower (0x0) and upper (0x4) speed limits; write them
//   only while no line is being closed.
// timing:
//   a byte is held in the input register, where the matcher and number
//   accumulator update state; a closing byte loads the result register at the
//   edge that retires it, and a full result register holds that byte back.
//   One byte is accepted every cycle, limited only by the result register.
// reset:
//   run off, speed reference 600000, limits 0 and 1200000, empty line, no result.
// stall:
//   while a result waits, bytes that give no result still flow; a closing byte
//   waits in the input register until the result register is taken.
module ascii_command_line_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  clp_rx_if.sink                      rx_i,
  clp_res_if.source                   res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [clp_pkg::APB_AW-1:0]  paddr,
  input  logic [clp_pkg::APB_DW-1:0]  pwdata,
  output logic [clp_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  clp_pkg::cfg_t cfg;
  clp_pkg::res_t res_next;
  logic          res_load;
  logic          out_free;

  clp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  clp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx         (rx_i),
    .cfg_i      (cfg),
    .out_free_i (out_free),
    .res_load_o (res_load),
    .res_o      (res_next)
  );

  clp_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (res_load),
    .res_i  (res_next),
    .free_o (out_free),
    .res    (res_o)
  );

endmodule

// ===== hw/rtl/clp_checker.sv =====
// clp_checker: port-level assertions for the command line parser, bound to the top
// depends on clp_pkg and ascii_command_line_parser
module clp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [clp_pkg::KIND_W-1:0]   line_kind,
  input logic                         run_enable,
  input logic                         stop_request,
  input logic [clp_pkg::SPEED_W-1:0]  ref_speed_milli
);

  // stop pulse only on stop lines
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (stop_request == (line_kind == clp_pkg::KIND_STOP)))
    else $error("stop_request disagrees with line kind");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (line_kind == clp_pkg::KIND_RUN) |-> run_enable)
    else $error("run line without run enable");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (line_kind == clp_pkg::KIND_STOP) |-> !run_enable)
    else $error("stop line with run enable");

  // with an empty result register the input side never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with no pending result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(ref_speed_milli) && $stable(line_kind))
    else $error("stalled result changed");

endmodule

bind ascii_command_line_parser clp_checker u_clp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready        (rx_i.ready),
  .out_valid       (res_o.valid),
  .out_ready       (res_o.ready),
  .line_kind       (res_o.line_kind),
  .run_enable      (res_o.run_enable),
  .stop_request    (res_o.stop_request),
  .ref_speed_milli (res_o.ref_speed_milli)
);
